// ----- design/tdm_pkg.sv -----
// Shared types and constants for the two source delay mixer.
`timescale 1ns / 1ps

package tdm_pkg;

  // Register file layout
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 24;
  localparam int NUM_OFS = 6;

  localparam logic [CFG_AW-1:0] REG_SRC1_DX = 3'd0;
  localparam logic [CFG_AW-1:0] REG_SRC1_DY = 3'd1;
  localparam logic [CFG_AW-1:0] REG_SRC1_DZ = 3'd2;
  localparam logic [CFG_AW-1:0] REG_SRC2_DX = 3'd3;
  localparam logic [CFG_AW-1:0] REG_SRC2_DY = 3'd4;
  localparam logic [CFG_AW-1:0] REG_SRC2_DZ = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RATE    = 3'd6;
  localparam logic [CFG_AW-1:0] REG_SPEED   = 3'd7;

  // Field widths
  localparam int OFS_W    = 24;
  localparam int RATE_W   = 18;
  localparam int SPEED_W  = 16;
  localparam int SAMPLE_W = 16;
  localparam int MIX_W    = 17;

  // Tap arithmetic widths
  localparam int SQR_W  = 48;
  localparam int ACC_W  = 50;
  localparam int DIST_W = 25;
  localparam int REM_W  = DIST_W + 2;
  localparam int NUM_W  = DIST_W + RATE_W;
  localparam int DEN_W  = SPEED_W + 8;
  localparam int CNT_W  = 5;

  localparam logic [RATE_W-1:0]  RATE_RST  = 18'd44100;
  localparam logic [SPEED_W-1:0] SPEED_RST = 16'd343;

  // Status of the tap unit toward the datapath
  typedef struct packed {
    logic ready;
    logic clip;
  } tap_stat_t;

endpackage

// ----- design/two_source_delay_mixer.sv -----
// Top level of the two source delay mixer: handshakes, item pipeline and output register.
//
//  port group  dir   payload (low bit first)           accepted when
//  in_         in    tdata: sample_in[15:0]            in_tvalid & in_tready
//  out_        out   tdata: mix_out[16:0], 7 zeros;    out_tvalid & out_tready
//                    tuser: tap_clipped
//  cfg_        in    addr: register, wdata: value      cfg_we
//
// One item per cycle while in_tready is high; a result passes the memory read register,
// then the output register. After reset and after each register write the tap unit
// recomputes both taps; in_tready stays low meanwhile. The delay line needs no clearing
// pass: a fill count masks entries never written. A stalled output holds the read stage,
// which holds in_tready low only when both are full.
`timescale 1ns / 1ps

module two_source_delay_mixer #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [15:0]                 in_tdata,   // sample_in[15:0]
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [23:0]                 out_tdata,  // mix_out[16:0], zero pad
  output logic                        out_tuser,  // tap_clipped
  input  logic                        cfg_we,
  input  logic [tdm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tdm_pkg::CFG_DW-1:0]  cfg_wdata
);

  localparam int AW = (LINE_DEPTH > 2) ? $clog2(LINE_DEPTH) : 1;

  logic [AW-1:0]                    tap1, tap2;
  tdm_pkg::tap_stat_t               stat;
  logic signed [tdm_pkg::MIX_W-1:0] mix;

  logic accept, s1_adv;
  logic s1_v_r, s1_clip_r;
  logic out_v_r, out_clip_r;
  logic [tdm_pkg::MIX_W-1:0] out_mix_r;

  tdm_tap_unit #(.LINE_DEPTH(LINE_DEPTH), .AW(AW)) u_tap (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .tap1      (tap1),
    .tap2      (tap2),
    .stat      (stat)
  );

  tdm_line #(.LINE_DEPTH(LINE_DEPTH), .AW(AW)) u_line (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (accept),
    .sample (in_tdata),
    .tap1   (tap1),
    .tap2   (tap2),
    .mix    (mix)
  );

  // Take an item when taps are settled, no register is written and the read stage can move
  assign s1_adv    = s1_v_r && (!out_v_r || out_tready);
  assign in_tready = stat.ready && !cfg_we && (!s1_v_r || s1_adv);
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (accept) s1_v_r <= 1'b1;
      else if (s1_adv) s1_v_r <= 1'b0;
      if (s1_adv) out_v_r <= 1'b1;
      else if (out_tready) out_v_r <= 1'b0;
    end
  end

  // Carry the clip flag with the item, load the output register
  always_ff @(posedge clk) begin
    if (accept) s1_clip_r <= stat.clip;
    if (s1_adv) begin
      out_mix_r  <= mix;
      out_clip_r <= s1_clip_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'b0, out_mix_r};
  assign out_tuser  = out_clip_r;

endmodule

// ----- design/tdm_tap_unit.sv -----
// Configuration registers and the sequential tap calculator (squares, root, divide).
`timescale 1ns / 1ps

module tdm_tap_unit #(
  parameter int LINE_DEPTH = 4096,
  parameter int AW         = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [tdm_pkg::CFG_AW-1:0]   cfg_addr,
  input  logic [tdm_pkg::CFG_DW-1:0]   cfg_wdata,
  output logic [AW-1:0]                tap1,
  output logic [AW-1:0]                tap2,
  output tdm_pkg::tap_stat_t           stat
);

  localparam int DW = (tdm_pkg::NUM_W > tdm_pkg::DEN_W + AW) ?
                      tdm_pkg::NUM_W : tdm_pkg::DEN_W + AW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SQ   = 3'd1;
  localparam logic [2:0] ST_ROOT = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_CHK  = 3'd4;
  localparam logic [2:0] ST_DIV  = 3'd5;

  localparam logic [DW:0]   DEPTH_W = (DW+1)'(LINE_DEPTH);
  localparam logic [AW-1:0] TAP_MAX = AW'(LINE_DEPTH - 1);

  logic [tdm_pkg::OFS_W-1:0]   ofs_r [tdm_pkg::NUM_OFS];
  logic [tdm_pkg::RATE_W-1:0]  rate_r;
  logic [tdm_pkg::SPEED_W-1:0] speed_r;

  logic [2:0]                  state_r, state_nxt;
  logic                        src_r, src_nxt;
  logic [tdm_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        clip_r, clip_nxt;
  logic [tdm_pkg::SQR_W-1:0]   prod_r, prod_nxt;
  logic [tdm_pkg::ACC_W-1:0]   acc_r, acc_nxt;
  logic [tdm_pkg::ACC_W-1:0]   n_r, n_nxt;
  logic [tdm_pkg::REM_W-1:0]   rem_r, rem_nxt;
  logic [tdm_pkg::DIST_W-1:0]  root_r, root_nxt;
  logic [DW-1:0]               num_r, num_nxt;
  logic [DW:0]                 lim_r, lim_nxt;
  logic [DW-1:0]               dsh_r, dsh_nxt;
  logic [AW-1:0]               q_r, q_nxt;
  logic [AW-1:0]               tap1_r, tap1_nxt;
  logic [AW-1:0]               tap2_r, tap2_nxt;

  logic [2:0]                  sel_idx;
  logic [tdm_pkg::OFS_W-1:0]   sel_ofs;
  logic [tdm_pkg::OFS_W-1:0]   sel_abs;
  logic [tdm_pkg::REM_W-1:0]   rem_cat;
  logic [tdm_pkg::REM_W-1:0]   trial;
  logic [tdm_pkg::DEN_W-1:0]   den;
  logic                        store;
  logic [AW-1:0]               store_tap;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tdm_pkg::NUM_OFS; i++) ofs_r[i] <= '0;
      rate_r  <= tdm_pkg::RATE_RST;
      speed_r <= tdm_pkg::SPEED_RST;
    end else if (cfg_we) begin
      if (cfg_addr == tdm_pkg::REG_RATE) begin
        rate_r <= cfg_wdata[tdm_pkg::RATE_W-1:0];
      end else if (cfg_addr == tdm_pkg::REG_SPEED) begin
        speed_r <= cfg_wdata[tdm_pkg::SPEED_W-1:0];
      end else begin
        ofs_r[cfg_addr] <= cfg_wdata;
      end
    end
  end

  // Pick and rectify the offset being squared
  always_comb begin
    sel_idx = (src_r ? tdm_pkg::REG_SRC2_DX : tdm_pkg::REG_SRC1_DX) + cnt_r[2:0];
    sel_ofs = ofs_r[sel_idx];
    sel_abs = sel_ofs[tdm_pkg::OFS_W-1] ? (~sel_ofs + 1'b1) : sel_ofs;
    rem_cat = {rem_r[tdm_pkg::REM_W-3:0], n_r[tdm_pkg::ACC_W-1 -: 2]};
    trial   = {root_r, 2'b01};
    den     = {speed_r, 8'h00};
  end

  // Sequence each source: squares, root digit by digit, scale, range check, restoring divide
  always_comb begin
    state_nxt = state_r;
    src_nxt   = src_r;
    cnt_nxt   = cnt_r;
    clip_nxt  = clip_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    n_nxt     = n_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    num_nxt   = num_r;
    lim_nxt   = lim_r;
    dsh_nxt   = dsh_r;
    q_nxt     = q_r;
    tap1_nxt  = tap1_r;
    tap2_nxt  = tap2_r;
    store     = 1'b0;
    store_tap = '0;

    unique case (state_r)
      ST_IDLE: ;
      ST_SQ: begin
        prod_nxt = tdm_pkg::SQR_W'(sel_abs * sel_abs);
        acc_nxt  = acc_r + ((cnt_r != '0) ? tdm_pkg::ACC_W'(prod_r) : '0);
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == tdm_pkg::CNT_W'(3)) begin
          n_nxt     = acc_r + tdm_pkg::ACC_W'(prod_r);
          rem_nxt   = '0;
          root_nxt  = '0;
          cnt_nxt   = '0;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rem_cat >= trial) begin
          rem_nxt  = rem_cat - trial;
          root_nxt = {root_r[tdm_pkg::DIST_W-2:0], 1'b1};
        end else begin
          rem_nxt  = rem_cat;
          root_nxt = {root_r[tdm_pkg::DIST_W-2:0], 1'b0};
        end
        n_nxt   = n_r << 2;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == tdm_pkg::CNT_W'(tdm_pkg::DIST_W - 1)) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        num_nxt   = DW'(root_r * rate_r);
        lim_nxt   = (DW+1)'(den * DEPTH_W);
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        if (num_r == '0) begin
          store = 1'b1;
        end else if (den == '0 || {1'b0, num_r} >= lim_r) begin
          clip_nxt  = 1'b1;
          store     = 1'b1;
          store_tap = TAP_MAX;
        end else begin
          dsh_nxt   = DW'(den) << (AW - 1);
          q_nxt     = '0;
          cnt_nxt   = tdm_pkg::CNT_W'(AW - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (num_r >= dsh_r) begin
          num_nxt = num_r - dsh_r;
          q_nxt   = (q_r << 1) | AW'(1);
        end else begin
          q_nxt = q_r << 1;
        end
        dsh_nxt = dsh_r >> 1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          store     = 1'b1;
          store_tap = q_nxt;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Latch a finished tap and move to the next source or go idle
    if (store) begin
      if (!src_r) begin
        tap1_nxt  = store_tap;
        src_nxt   = 1'b1;
        cnt_nxt   = '0;
        acc_nxt   = '0;
        state_nxt = ST_SQ;
      end else begin
        tap2_nxt  = store_tap;
        state_nxt = ST_IDLE;
      end
    end

    // Any register write restarts the calculation
    if (cfg_we) begin
      state_nxt = ST_SQ;
      src_nxt   = 1'b0;
      cnt_nxt   = '0;
      acc_nxt   = '0;
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_SQ;
      src_r   <= 1'b0;
      cnt_r   <= '0;
      clip_r  <= 1'b0;
      acc_r   <= '0;
    end else begin
      state_r <= state_nxt;
      src_r   <= src_nxt;
      cnt_r   <= cnt_nxt;
      clip_r  <= clip_nxt;
      acc_r   <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    n_r    <= n_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    num_r  <= num_nxt;
    lim_r  <= lim_nxt;
    dsh_r  <= dsh_nxt;
    q_r    <= q_nxt;
    tap1_r <= tap1_nxt;
    tap2_r <= tap2_nxt;
  end

  assign tap1       = tap1_r;
  assign tap2       = tap2_r;
  assign stat.ready = (state_r == ST_IDLE);
  assign stat.clip  = clip_r;

endmodule

// ----- design/tdm_line.sv -----
// Delay line memory with write pointer, fill count and two registered tap reads.
`timescale 1ns / 1ps

module tdm_line #(
  parameter int LINE_DEPTH = 4096,
  parameter int AW         = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en,
  input  logic signed [tdm_pkg::SAMPLE_W-1:0] sample,
  input  logic [AW-1:0]                       tap1,
  input  logic [AW-1:0]                       tap2,
  output logic signed [tdm_pkg::MIX_W-1:0]    mix
);

  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam logic [AW:0]   DEPTH_A = (AW+1)'(LINE_DEPTH);
  localparam logic [AW-1:0] LAST    = AW'(LINE_DEPTH - 1);
  localparam logic [CW-1:0] FULL    = CW'(LINE_DEPTH);

  logic [tdm_pkg::SAMPLE_W-1:0] mem [LINE_DEPTH];

  logic [AW-1:0] wp_r;
  logic [CW-1:0] fill_r;
  logic [AW-1:0] addr1, addr2;
  logic          ok1, ok2;

  logic [tdm_pkg::SAMPLE_W-1:0] rd1_r, rd2_r, samp_r;
  logic ok1_r, ok2_r, zero1_r, zero2_r;
  logic signed [tdm_pkg::SAMPLE_W-1:0] v1, v2;

  // Address the taps behind the write pointer, modulo the depth
  always_comb begin
    addr1 = (wp_r >= tap1) ? (wp_r - tap1) : AW'({1'b0, wp_r} + DEPTH_A - {1'b0, tap1});
    addr2 = (wp_r >= tap2) ? (wp_r - tap2) : AW'({1'b0, wp_r} + DEPTH_A - {1'b0, tap2});
    ok1   = CW'(tap1) <= fill_r;
    ok2   = CW'(tap2) <= fill_r;
  end

  // Advance pointer and fill count per item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (wr_en) begin
      wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      if (fill_r != FULL) fill_r <= fill_r + 1'b1;
    end
  end

  // Write the new sample, read both taps
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp_r] <= sample;
      rd1_r     <= mem[addr1];
      rd2_r     <= mem[addr2];
      samp_r    <= sample;
      ok1_r     <= ok1;
      ok2_r     <= ok2;
      zero1_r   <= (tap1 == '0);
      zero2_r   <= (tap2 == '0);
    end
  end

  // Forward a zero tap, drop entries never written
  always_comb begin
    v1  = zero1_r ? samp_r : (ok1_r ? rd1_r : '0);
    v2  = zero2_r ? samp_r : (ok2_r ? rd2_r : '0);
    mix = tdm_pkg::MIX_W'(v1) + tdm_pkg::MIX_W'(v2);
  end

endmodule

// ----- dv/two_source_delay_mixer_chk.sv -----
// Checker for the two source delay mixer: tracks taps and delay line, compares results.
`timescale 1ns / 1ps

module two_source_delay_mixer_chk #(
  parameter int LINE_DEPTH = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  input  logic                        in_tready,
  input  logic [15:0]                 in_tdata,
  input  logic                        out_tvalid,
  input  logic                        out_tready,
  input  logic [23:0]                 out_tdata,
  input  logic                        out_tuser,
  input  logic                        cfg_we,
  input  logic [tdm_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [tdm_pkg::CFG_DW-1:0]  cfg_wdata,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [tdm_pkg::MIX_W-1:0] mix;
    logic                      clip;
  } mix_res_t;

  logic [23:0] ofs [tdm_pkg::NUM_OFS];
  logic [tdm_pkg::RATE_W-1:0]  rate;
  logic [tdm_pkg::SPEED_W-1:0] speed;
  logic signed [15:0] line_mem [LINE_DEPTH];
  int unsigned wr_ptr;
  mix_res_t mix_q[$];

  assign pending = mix_q.size();

  function automatic longint unsigned mag24(logic [23:0] v);
    longint s;
    s = longint'(signed'(v));
    return (s < 0) ? -s : s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Delay in samples for the source whose x offset sits at base
  function automatic int unsigned tap_of(int base, inout logic clip);
    longint unsigned ax, ay, az, src_dist, num, den, t;
    ax = mag24(ofs[base]);
    ay = mag24(ofs[base+1]);
    az = mag24(ofs[base+2]);
    src_dist = root_floor(ax*ax + ay*ay + az*az);
    num = src_dist * rate;
    den = longint'(speed) * 256;
    if (num == 0) return 0;
    if (den == 0) begin
      clip = 1'b1;
      return LINE_DEPTH - 1;
    end
    t = num / den;
    if (t > LINE_DEPTH - 1) begin
      clip = 1'b1;
      return LINE_DEPTH - 1;
    end
    return t;
  endfunction

  always @(posedge clk) begin
    logic clip;
    int unsigned t1, t2;
    mix_res_t got, exp_r;
    int s;
    if (!rst_n) begin
      foreach (ofs[i]) ofs[i] <= '0;
      rate <= tdm_pkg::RATE_RST;
      speed <= tdm_pkg::SPEED_RST;
      foreach (line_mem[i]) line_mem[i] = '0;
      wr_ptr = 0;
      mix_q.delete();
      errors <= 0;
    end else begin
      // Register writes
      if (cfg_we) begin
        if (cfg_addr == tdm_pkg::REG_RATE) rate <= cfg_wdata[tdm_pkg::RATE_W-1:0];
        else if (cfg_addr == tdm_pkg::REG_SPEED) speed <= cfg_wdata[tdm_pkg::SPEED_W-1:0];
        else if (cfg_addr < tdm_pkg::REG_RATE) ofs[cfg_addr] <= cfg_wdata;
      end
      // Predict on each accepted item
      if (in_tvalid && in_tready) begin
        clip = 1'b0;
        t1 = tap_of(tdm_pkg::REG_SRC1_DX, clip);
        t2 = tap_of(tdm_pkg::REG_SRC2_DX, clip);
        line_mem[wr_ptr] = in_tdata;
        s = int'(line_mem[(wr_ptr + LINE_DEPTH - t1) % LINE_DEPTH])
          + int'(line_mem[(wr_ptr + LINE_DEPTH - t2) % LINE_DEPTH]);
        exp_r.mix = s[tdm_pkg::MIX_W-1:0];
        exp_r.clip = clip;
        mix_q.insert(mix_q.size(), exp_r);
        wr_ptr = (wr_ptr + 1) % LINE_DEPTH;
      end
      // Compare each accepted result
      if (out_tvalid && out_tready) begin
        got.mix = out_tdata[tdm_pkg::MIX_W-1:0];
        got.clip = out_tuser;
        if (mix_q.size() == 0) begin
          $display("%0t: unexpected result mix=%0d clip=%0b", $time,
                   $signed(got.mix), got.clip);
          errors <= errors + 1;
        end else begin
          exp_r = mix_q.pop_front();
          if (got !== exp_r || out_tdata[23:tdm_pkg::MIX_W] !== '0) begin
            $display("%0t: mismatch expected mix=%0d clip=%0b actual mix=%0d clip=%0b pad=%h",
                     $time, $signed(exp_r.mix), exp_r.clip, $signed(got.mix), got.clip,
                     out_tdata[23:tdm_pkg::MIX_W]);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

// ----- dv/two_source_delay_mixer_tb.sv -----
// Testbench top for the two source delay mixer: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module two_source_delay_mixer_tb;

  localparam int DEPTH = 4096;
  localparam int SETTLE = 200;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic out_tuser;
  logic cfg_we = 1'b0;
  logic [tdm_pkg::CFG_AW-1:0] cfg_addr = '0;
  logic [tdm_pkg::CFG_DW-1:0] cfg_wdata = '0;
  int errors, pending;
  bit out_busy = 1'b0;

  always #5 clk = ~clk;

  two_source_delay_mixer #(.LINE_DEPTH(DEPTH)) dut (.*);

  two_source_delay_mixer_chk #(.LINE_DEPTH(DEPTH)) chk (.*);

  // Receiver: random stall per item, with quiet stretches
  initial begin
    int w;
    forever begin
      w = 0;
      if (out_busy) w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_sample(logic [15:0] v, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 17) : 0;
    if (w > 0) begin
      in_tvalid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!(in_tvalid && in_tready));
  endtask

  task automatic drain_all();
    in_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [tdm_pkg::CFG_AW-1:0] a, logic [tdm_pkg::CFG_DW-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_sources(int s1x, int s1y, int s1z, int s2x, int s2y, int s2z,
                             int r, int sp);
    write_reg(tdm_pkg::REG_SRC1_DX, s1x);
    write_reg(tdm_pkg::REG_SRC1_DY, s1y);
    write_reg(tdm_pkg::REG_SRC1_DZ, s1z);
    write_reg(tdm_pkg::REG_SRC2_DX, s2x);
    write_reg(tdm_pkg::REG_SRC2_DY, s2y);
    write_reg(tdm_pkg::REG_SRC2_DZ, s2z);
    write_reg(tdm_pkg::REG_RATE, r);
    write_reg(tdm_pkg::REG_SPEED, sp);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic logic [tdm_pkg::CFG_DW-1:0] rnd_ofs(int span);
    return $urandom_range(0, 2*span) - span;
  endfunction

  initial begin
    logic [15:0] edge_vals[6] = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h5555};
    int n_items;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (SETTLE) @(posedge clk);

    // Reset settings: both sources at the microphone, zero taps
    foreach (edge_vals[i]) send_sample(edge_vals[i], 1'b0);
    send_sample(16'hAAAA, 1'b1);
    drain_all();

    // Short taps: 1 m and 2 m at 343 m/s, 44.1 kHz (about 128 and 257 samples)
    set_sources(256, 0, 0, 0, -512, 0, 44100, 343);
    for (int i = 0; i < 8; i++) send_sample(edge_vals[i % 6], 1'b1);
    drain_all();

    // Extreme offsets: taps saturate; then zero speed, then zero rate
    set_sources(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
                192000, 65535);
    for (int i = 0; i < 4; i++) send_sample(edge_vals[i], 1'b0);
    drain_all();
    set_sources(5, 0, 0, 0, 0, 0, 1, 0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    drain_all();
    set_sources(256, 256, 256, 1000, 0, 0, 0, 0);
    send_sample(16'h1234, 1'b0);
    send_sample(16'hFEDC, 1'b0);
    drain_all();
    // Lone register write, then let the taps settle
    write_reg(tdm_pkg::REG_SRC1_DX, 24'd0);
    drain_all();

    // Random phases: mostly short taps, some saturating, random settings
    n_items = 0;
    for (int ph = 0; n_items < 1100; ph++) begin
      case (ph % 4)
        0: set_sources(rnd_ofs(400), rnd_ofs(400), rnd_ofs(400),
                       rnd_ofs(400), rnd_ofs(400), rnd_ofs(400),
                       $urandom_range(8000, 48000), $urandom_range(300, 400));
        1: set_sources(rnd_ofs(20), rnd_ofs(20), 0, 0, rnd_ofs(20), rnd_ofs(20),
                       $urandom_range(1, 192000), $urandom_range(1, 65535));
        2: set_sources($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom_range(0, 262143), $urandom_range(0, 65535));
        default: set_sources(rnd_ofs(2000), 0, 0, rnd_ofs(6000), 0, 0,
                             $urandom_range(1000, 192000), $urandom_range(100, 2000));
      endcase
      for (int i = 0; i < 140; i++) begin
        send_sample($urandom, ($urandom_range(0, 2) != 0) && (i < 60 || i > 100));
        n_items++;
      end
      drain_all();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    @(posedge rst_n);
    out_busy = 1'b1;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
